FILE: hdl/dai64_pkg.sv
// package: status codes, register indexes and parse constants for the decimal to int64 converter
package dai64_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DECODE = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic {
        REG_MIN = 1'b0,
        REG_MAX = 1'b1
    } reg_idx_t;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // largest magnitude that can still take another digit, and the last digit allowed there
    localparam logic [63:0] MAG_CUT = 64'd922337203685477580;
    localparam logic [3:0]  POS_REM = 4'd7;
    localparam logic [3:0]  NEG_REM = 4'd8;

    localparam logic signed [63:0] MIN_RESET = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] MAX_RESET = 64'sh7FFF_FFFF_FFFF_FFFF;

endpackage

FILE: hdl/dai64_stream_if.sv
// interfaces: byte stream and result stream channels with valid/ready handshake
interface dai64_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;
    logic       empty_field;

    modport source (output valid, output char_byte, output last_byte, output empty_field,
                    input ready);
    modport sink   (input valid, input char_byte, input last_byte, input empty_field,
                    output ready);
endinterface

interface dai64_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] parsed_value;
    logic [1:0]         status;

    modport source (output valid, output parsed_value, output status, input ready);
    modport sink   (input valid, input parsed_value, input status, output ready);
endinterface

FILE: hdl/decimal_ascii_to_int64_top.sv
// top level: decimal ascii field to signed 64-bit integer with overflow and range check
//
// channel         role    payload
// byte_stream     sink    char_byte[7:0], last_byte, empty_field
// result_stream   source  parsed_value[63:0] signed, status[1:0]
// apb             slave   min_value at 0x0, max_value at 0x8, 64-bit data
//
// one byte per cycle while no field end waits; three register stages: input, finished field,
// result; a field-ending byte moves from input to finished field to result register
// the parse step keeps the per-field state (magnitude, sign, digit seen, first error)
// the final stage negates the magnitude and compares against min and max
// a held result backs up through the stages; any byte waits while a field-ending byte is stuck
// in the input register
// rst_n clears all control state and sets min/max to the full signed range
module decimal_ascii_to_int64_top
    import dai64_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    dai64_byte_if.sink     byte_stream,
    dai64_result_if.source result_stream,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);

    logic signed [63:0] min_reg;
    logic signed [63:0] max_reg;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    logic [63:0] mag_reg;
    logic        neg_reg;
    logic        seen_reg;
    logic        first_reg;
    status_t     perr_reg;

    logic        fin_valid_reg;
    logic [63:0] fin_mag_reg;
    logic        fin_neg_reg;
    status_t     fin_err_reg;

    logic               out_valid_reg;
    logic signed [63:0] out_value_reg;
    status_t            out_status_reg;

    logic        out_free;
    logic        fin_free;
    logic        ends;
    logic        parse_go;
    logic        in_free;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    logic [7:0]  digit_byte;
    logic [3:0]  digit;
    logic        is_digit;
    logic        is_sign;
    logic        ovf;
    logic [3:0]  lim_rem;
    logic [63:0] mag_step;
    logic [63:0] mag_next;
    logic        neg_next;
    logic        seen_next;
    status_t     perr_next;
    status_t     fin_err_next;

    logic signed [63:0] fin_value;
    logic               range_bad;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3]);
    assign prdata    = (cfg_idx == REG_MAX) ? max_reg : min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MIN: min_reg <= pwdata;
                REG_MAX: max_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // stage handshakes
    assign out_free = !out_valid_reg || result_stream.ready;
    assign fin_free = !fin_valid_reg || out_free;
    assign ends     = in_empty_reg || in_last_reg;
    assign parse_go = in_valid_reg && (!ends || fin_free);
    assign in_free  = !in_valid_reg || !ends || fin_free;
    assign byte_stream.ready = in_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && byte_stream.valid)
        begin
            in_char_reg  <= byte_stream.char_byte;
            in_last_reg  <= byte_stream.last_byte;
            in_empty_reg <= byte_stream.empty_field;
        end
    end

    // parse step
    always_comb
    begin
        digit_byte = in_char_reg - CHAR_ZERO;
        digit      = digit_byte[3:0];
        is_digit   = in_char_reg inside {[CHAR_ZERO:CHAR_NINE]};
        is_sign    = first_reg && ((in_char_reg == CHAR_PLUS) || (in_char_reg == CHAR_MINUS));
        lim_rem    = neg_reg ? NEG_REM : POS_REM;
        ovf        = (mag_reg > MAG_CUT) || ((mag_reg == MAG_CUT) && (digit > lim_rem));
        mag_step   = (mag_reg << 3) + (mag_reg << 1) + {60'd0, digit};

        mag_next  = mag_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        perr_next = perr_reg;

        if (perr_reg == ST_OK)
        begin
            if (is_sign)
            begin
                neg_next = (in_char_reg == CHAR_MINUS);
            end
            else if (is_digit)
            begin
                if (ovf)
                begin
                    perr_next = ST_RANGE;
                end
                else
                begin
                    mag_next  = mag_step;
                    seen_next = 1'b1;
                end
            end
            else
            begin
                perr_next = ST_DECODE;
            end
        end

        if (in_empty_reg)
        begin
            fin_err_next = ST_DECODE;
        end
        else if (perr_next != ST_OK)
        begin
            fin_err_next = perr_next;
        end
        else if (!seen_next)
        begin
            fin_err_next = ST_DECODE;
        end
        else
        begin
            fin_err_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            first_reg <= 1'b1;
            perr_reg  <= ST_OK;
        end
        else if (parse_go)
        begin
            if (ends)
            begin
                mag_reg   <= '0;
                neg_reg   <= 1'b0;
                seen_reg  <= 1'b0;
                first_reg <= 1'b1;
                perr_reg  <= ST_OK;
            end
            else
            begin
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                first_reg <= 1'b0;
                perr_reg  <= perr_next;
            end
        end
    end

    // finished field register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_free)
        begin
            fin_valid_reg <= in_valid_reg && ends;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_free && in_valid_reg && ends)
        begin
            fin_mag_reg <= mag_next;
            fin_neg_reg <= neg_next;
            fin_err_reg <= fin_err_next;
        end
    end

    // sign apply and range check
    assign fin_value = fin_neg_reg ? -$signed(fin_mag_reg) : $signed(fin_mag_reg);
    assign range_bad = (fin_value < min_reg) || (fin_value > max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fin_valid_reg)
        begin
            if (fin_err_reg != ST_OK)
            begin
                out_value_reg  <= '0;
                out_status_reg <= fin_err_reg;
            end
            else if (range_bad)
            begin
                out_value_reg  <= '0;
                out_status_reg <= ST_RANGE;
            end
            else
            begin
                out_value_reg  <= fin_value;
                out_status_reg <= ST_OK;
            end
        end
    end

    assign result_stream.valid        = out_valid_reg;
    assign result_stream.parsed_value = out_value_reg;
    assign result_stream.status       = out_status_reg;

endmodule

FILE: tb/decimal_ascii_to_int64_top_tb.sv
// testbench: random and directed decimal fields through the int64 converter, checked by a predictor
`timescale 1ns / 100ps

module decimal_ascii_to_int64_top_tb;
    import dai64_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_byte;
        logic       empty_field;
    } field_byte_t;

    typedef struct {
        logic signed [63:0] value;
        status_t            status;
    } conv_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    dai64_byte_if   byte_if ();
    dai64_result_if res_if ();

    decimal_ascii_to_int64_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .result_stream (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    field_byte_t  pending_bytes[$];
    conv_result_t conv_expected[$];
    logic [7:0]   fbuf[$];

    int  bytes_queued = 0;
    int  bytes_accepted = 0;
    int  err_cnt = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    bit  idle_en = 1'b1;
    bit  byte_fire = 1'b0;

    // predictor state and register copies
    logic [63:0]        acc_val;
    logic               acc_neg;
    logic               got_digit;
    logic               first_pos;
    status_t            field_err;
    logic signed [63:0] lim_lo;
    logic signed [63:0] lim_hi;

    field_byte_t  drv_item;
    field_byte_t  mon_item;
    conv_result_t mon_res;
    conv_result_t exp_res;

    always #5 clk = ~clk;

    initial
    begin
        byte_if.valid       = 1'b0;
        byte_if.char_byte   = '0;
        byte_if.last_byte   = 1'b0;
        byte_if.empty_field = 1'b0;
        res_if.ready        = 1'b0;
    end

    function automatic void clear_field();
        acc_val   = '0;
        acc_neg   = 1'b0;
        got_digit = 1'b0;
        first_pos = 1'b1;
        field_err = ST_OK;
    endfunction

    function automatic bit parse_byte(input field_byte_t it, output conv_result_t res);
        logic [63:0] digit;
        logic [63:0] mag;
        logic [63:0] bound;
        res.value  = '0;
        res.status = ST_DECODE;
        if (it.empty_field)
        begin
            clear_field();
            return 1'b1;
        end
        if (field_err == ST_OK)
        begin
            if (first_pos && (it.ch == CHAR_PLUS || it.ch == CHAR_MINUS))
                acc_neg = (it.ch == CHAR_MINUS);
            else if (it.ch >= CHAR_ZERO && it.ch <= CHAR_NINE)
            begin
                digit = 64'(it.ch - CHAR_ZERO);
                bound = acc_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                mag   = acc_neg ? -acc_val : acc_val;
                if (mag > bound / 10 || (mag == bound / 10 && digit > bound % 10))
                    field_err = ST_RANGE;
                else
                begin
                    acc_val   = acc_neg ? acc_val * 10 - digit : acc_val * 10 + digit;
                    got_digit = 1'b1;
                end
            end
            else
                field_err = ST_DECODE;
        end
        first_pos = 1'b0;
        if (!it.last_byte)
            return 1'b0;
        if (field_err != ST_OK)
            res.status = field_err;
        else if (!got_digit)
            res.status = ST_DECODE;
        else if ($signed(acc_val) < lim_lo || $signed(acc_val) > lim_hi)
            res.status = ST_RANGE;
        else
        begin
            res.value  = acc_val;
            res.status = ST_OK;
        end
        clear_field();
        return 1'b1;
    endfunction

    // byte source
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_if.valid <= 1'b0;
        else if (!byte_if.valid || byte_fire)
        begin
            if (src_gap > 0 || pending_bytes.size() == 0)
            begin
                byte_if.valid <= 1'b0;
                if (src_gap > 0)
                    src_gap--;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                byte_if.valid <= 1'b0;
                src_gap = $urandom_range(0, 14);
            end
            else
            begin
                drv_item = pending_bytes.pop_front();
                byte_if.char_byte   <= drv_item.ch;
                byte_if.last_byte   <= drv_item.last_byte;
                byte_if.empty_field <= drv_item.empty_field;
                byte_if.valid       <= 1'b1;
            end
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (snk_gap > 0)
        begin
            res_if.ready <= 1'b0;
            snk_gap--;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            res_if.ready <= 1'b0;
            snk_gap = $urandom_range(0, 14);
        end
        else
            res_if.ready <= 1'b1;
    end

    // monitor: predict on each byte transaction, check each result transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_fire <= 1'b0;
        else
        begin
            byte_fire <= byte_if.valid && byte_if.ready;
            if (byte_if.valid && byte_if.ready)
            begin
                bytes_accepted++;
                mon_item = '{byte_if.char_byte, byte_if.last_byte, byte_if.empty_field};
                if (parse_byte(mon_item, mon_res))
                    conv_expected.push_back(mon_res);
            end
            if (res_if.valid && res_if.ready)
            begin
                if (conv_expected.size() == 0)
                begin
                    $error("unexpected result: parsed_value %0d status %0d",
                           res_if.parsed_value, res_if.status);
                    err_cnt++;
                end
                else
                begin
                    exp_res = conv_expected.pop_front();
                    if (res_if.parsed_value !== exp_res.value)
                    begin
                        $error("parsed_value: expected %0d, actual %0d",
                               exp_res.value, res_if.parsed_value);
                        err_cnt++;
                    end
                    if (res_if.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, res_if.status);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] ch, input logic last_b, input logic empty_f);
        pending_bytes.push_back('{ch, last_b, empty_f});
        bytes_queued++;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            fbuf.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++)
            fbuf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_sign();
        case ($urandom_range(0, 2))
            1: fbuf.push_back(CHAR_PLUS);
            2: fbuf.push_back(CHAR_MINUS);
            default: ;
        endcase
    endtask

    // close = 0 leaves the field open for a following empty transaction
    task automatic flush(input bit close);
        for (int i = 0; i < fbuf.size(); i++)
            push_byte(fbuf[i], close && i == fbuf.size() - 1, 1'b0);
        fbuf.delete();
    endtask

    task automatic field(input string s);
        add_str(s);
        flush(1'b1);
    endtask

    task automatic push_empty(input logic last_b);
        push_byte(8'($urandom_range(0, 255)), last_b, 1'b1);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic signed [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN)
            lim_lo = val;
        else
            lim_hi = val;
    endtask

    task automatic set_limits(input logic signed [63:0] lo, input logic signed [63:0] hi);
        reg_write(REG_MIN, lo);
        reg_write(REG_MAX, hi);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (bytes_accepted != bytes_queued || conv_expected.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(input int nbytes);
        int                 start;
        int                 kind;
        int                 k;
        int                 off;
        logic signed [63:0] v;
        start = bytes_queued;
        while (bytes_queued - start < nbytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                add_sign();
                if ($urandom_range(0, 9) == 0)
                    add_digits($urandom_range(15, 20));
                else
                    add_digits($urandom_range(1, 6));
                flush(1'b1);
            end
            else if (kind < 55)
            begin
                // around the 64-bit limits
                add_sign();
                add_str("922337203685477580");
                add_digits(1);
                if ($urandom_range(0, 3) == 0)
                    add_digits(1);
                flush(1'b1);
            end
            else if (kind < 70)
            begin
                off = $urandom_range(0, 6) - 3;
                case ($urandom_range(0, 2))
                    0: v = {$urandom, $urandom};
                    1: v = lim_lo + off;
                    default: v = lim_hi + off;
                endcase
                if (v >= 0 && $urandom_range(0, 1))
                    fbuf.push_back(CHAR_PLUS);
                add_str($sformatf("%0d", v));
                flush(1'b1);
            end
            else if (kind < 82)
            begin
                // malformed number: stray byte or misplaced sign
                add_sign();
                add_digits($urandom_range(1, 6));
                if ($urandom_range(0, 1))
                begin
                    k = $urandom_range(0, fbuf.size() - 1);
                    fbuf[k] = 8'($urandom_range(0, 255));
                end
                else
                begin
                    k = $urandom_range(1, fbuf.size());
                    fbuf.insert(k, $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                end
                flush(1'b1);
            end
            else if (kind < 90)
            begin
                if ($urandom_range(0, 1))
                begin
                    add_sign();
                    add_digits($urandom_range(1, 4));
                    flush(1'b0);
                end
                push_empty($urandom_range(0, 1));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    fbuf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                else
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        fbuf.push_back(8'($urandom_range(0, 255)));
                flush(1'b1);
            end
        end
    endtask

    initial
    begin
        clear_field();
        lim_lo = MIN_RESET;
        lim_hi = MAX_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        field("0");
        field("9");
        field("+7");
        field("-0");
        field("9223372036854775807");
        field("9223372036854775808");
        field("-9223372036854775808");
        field("-9223372036854775809");
        field("+");
        field("-");
        field("12-3");
        field("4+");
        field("1x99");
        field("--1");
        push_empty(1'b1);
        add_str("55");
        flush(1'b0);
        push_empty(1'b0);
        field("00000000000000000000042");
        field("99999999999999999999");
        fbuf.push_back(8'h2F);
        flush(1'b1);
        add_str("1");
        fbuf.push_back(8'h3A);
        flush(1'b1);
        fbuf.push_back(8'hFF);
        fbuf.push_back(8'h00);
        flush(1'b1);
        fbuf.push_back(8'h80);
        flush(1'b1);
        drain();

        run_random(200);
        drain();
        set_limits(64'sd0, 64'sd1000);
        run_random(220);
        drain();
        set_limits(-64'sd1000, -64'sd5);
        run_random(220);
        drain();
        set_limits(64'sd100, -64'sd100);
        run_random(200);
        drain();
        set_limits(MIN_RESET, MIN_RESET);
        run_random(200);
        drain();
        set_limits(MAX_RESET, MAX_RESET);
        run_random(200);
        drain();
        set_limits(MIN_RESET, MAX_RESET);
        idle_en = 1'b0;
        run_random(220);
        drain();

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
